>>> rtl/sis_pkg.sv
// sis_pkg: shared types and constants for the sorted insertion store.
// Used by sis_cell and sorted_insertion_store_top; depends on nothing.
package sis_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     rot;
        logic signed [DATA_W-1:0] ins_value;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] head;
    } cell_ctrl_t;

endpackage

>>> rtl/sis_cell.sv
// sis_cell: one compare-and-shift cell of the sorted chain.
// Depends on sis_pkg for widths and the broadcast control struct.
module sis_cell
(
    input  logic                              clk,
    input  sis_pkg::cell_ctrl_t               ctrl,
    input  logic [sis_pkg::IDX_W-1:0]         idx,
    input  logic signed [sis_pkg::DATA_W-1:0] left_value,
    input  logic                              left_le,
    input  logic signed [sis_pkg::DATA_W-1:0] right_value,
    output logic signed [sis_pkg::DATA_W-1:0] value,
    output logic                              le
);

    logic signed [sis_pkg::DATA_W-1:0] value_reg;
    logic signed [sis_pkg::DATA_W-1:0] value_next;
    logic [sis_pkg::CNT_W-1:0]         my_pos;
    logic                              occupied;
    logic                              ring_end;

    assign my_pos   = sis_pkg::CNT_W'(idx);
    assign occupied = my_pos < ctrl.count;
    // entry <= new value: new value lands after it
    assign le       = occupied && (value_reg <= ctrl.ins_value);
    assign ring_end = (my_pos + sis_pkg::CNT_W'(1)) == ctrl.count;
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins && !le)
        begin
            // first cell not <= value takes it, later ones shift right
            value_next = left_le ? ctrl.ins_value : left_value;
        end
        else if (ctrl.rot)
        begin
            // read-out rotates the occupied cells by one toward cell 0
            value_next = ring_end ? ctrl.head : right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> rtl/sorted_insertion_store_top.sv
// sorted_insertion_store_top: chain of sis_cell cells plus request control.
// Depends on sis_pkg and sis_cell.
//
// Usage:
//   Input channel (in_valid/in_stall, kind, value) takes one request at a
//   time. kind = insert places value after all stored values <= it, so
//   equal values keep arrival order; kind = read streams the store out.
//   Output channel (out_valid/out_stall) carries data, last, is_empty,
//   rejected and occupancy, held in an output register.
//   An insert is answered in the cycle after acceptance; the chain of
//   cells compares all entries in parallel and shifts in that same cycle,
//   so inserts run at one per cycle while the output is taken.
//   A read of N stored values yields N results, one per cycle while the output is
//   taken, by rotating the occupied cells toward cell 0 and emitting cell 0 in the
//   read state; after N steps the chain is back in order. Input stalls meanwhile.
//   Empty read: one result with is_empty set. Insert into a full store
//   (CAPACITY values) is dropped and answered with rejected set.
//   Reset clears the count and the control; the cell contents are not
//   cleared, only cells below the count are ever read.
//   A stalled output holds its result and stalls the input in turn.
module sorted_insertion_store_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic signed [sis_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sis_pkg::DATA_W-1:0] data,
    output logic                              last,
    output logic                              is_empty,
    output logic                              rejected,
    output logic [sis_pkg::OCC_W-1:0]         occupancy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                      state_reg, state_next;
    logic [sis_pkg::CNT_W-1:0] count_reg, count_next;
    logic [sis_pkg::CNT_W-1:0] rd_idx_reg, rd_idx_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [sis_pkg::DATA_W-1:0] data_reg, data_next;
    logic                              last_reg, last_next;
    logic                              empty_reg, empty_next;
    logic                              rej_reg, rej_next;
    logic [sis_pkg::OCC_W-1:0]         occ_reg, occ_next;

    logic                 out_free;
    logic                 accept;
    logic                 full;
    logic                 do_ins;
    logic                 read_step;
    logic                 read_last;
    sis_pkg::cell_ctrl_t  ctrl;

    logic signed [sis_pkg::DATA_W-1:0] cell_value [sis_pkg::CAPACITY];
    logic                              cell_le    [sis_pkg::CAPACITY];

    assign full      = count_reg == sis_pkg::CNT_W'(sis_pkg::CAPACITY);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign do_ins    = accept && (kind == sis_pkg::KIND_INSERT) && !full;
    assign read_step = (state_reg == ST_READ) && out_free;
    assign read_last = (rd_idx_reg + sis_pkg::CNT_W'(1)) == count_reg;

    assign ctrl.ins       = do_ins;
    assign ctrl.rot       = read_step;
    assign ctrl.ins_value = value;
    assign ctrl.count     = count_reg;
    assign ctrl.head      = cell_value[0];

    // the cell chain
    for (genvar i = 0; i < sis_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [sis_pkg::DATA_W-1:0] lv;
        logic                              ll;
        logic signed [sis_pkg::DATA_W-1:0] rv;

        if (i == 0)
        begin : g_first
            assign lv = value;
            assign ll = 1'b1;
        end
        else
        begin : g_mid
            assign lv = cell_value[i-1];
            assign ll = cell_le[i-1];
        end

        if (i == sis_pkg::CAPACITY - 1)
        begin : g_end
            assign rv = cell_value[0];
        end
        else
        begin : g_nend
            assign rv = cell_value[i+1];
        end

        sis_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .idx         (sis_pkg::IDX_W'(i)),
            .left_value  (lv),
            .left_le     (ll),
            .right_value (rv),
            .value       (cell_value[i]),
            .le          (cell_le[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        rej_next       = rej_reg;
        occ_next       = occ_reg;

        if (out_free)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (kind == sis_pkg::KIND_INSERT)
            begin
                // insert request: answer right away
                out_valid_next = 1'b1;
                data_next      = '0;
                last_next      = 1'b1;
                empty_next     = 1'b0;
                rej_next       = full;
                if (full)
                begin
                    occ_next = sis_pkg::OCC_W'(count_reg);
                end
                else
                begin
                    count_next = count_reg + sis_pkg::CNT_W'(1);
                    occ_next   = sis_pkg::OCC_W'(count_reg + sis_pkg::CNT_W'(1));
                end
            end
            else if (count_reg == '0)
            begin
                out_valid_next = 1'b1;
                data_next      = '0;
                last_next      = 1'b1;
                empty_next     = 1'b1;
                rej_next       = 1'b0;
                occ_next       = '0;
            end
            else
            begin
                state_next  = ST_READ;
                rd_idx_next = '0;
            end
        end

        if (read_step)
        begin
            out_valid_next = 1'b1;
            data_next      = cell_value[0];
            last_next      = read_last;
            empty_next     = 1'b0;
            rej_next       = 1'b0;
            occ_next       = sis_pkg::OCC_W'(count_reg);
            rd_idx_next    = rd_idx_reg + sis_pkg::CNT_W'(1);
            if (read_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        rej_reg   <= rej_next;
        occ_reg   <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign last      = last_reg;
    assign is_empty  = empty_reg;
    assign rejected  = rej_reg;
    assign occupancy = occ_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sis_pkg::CNT_W'(sis_pkg::CAPACITY))
        else $error("count exceeds capacity");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (count_reg != '0) && (rd_idx_reg < count_reg))
        else $error("read-out running past stored values");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> count_reg == $past(count_reg) + sis_pkg::CNT_W'(1))
        else $error("insert did not grow the count");

    a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (count_reg == sis_pkg::CNT_W'(sis_pkg::CAPACITY)))
        else $error("reject reported with room left");
`endif

endmodule
